### sv/plbb_pkg.sv
// Package for the per-label bounding box block: widths, codes, confidence tables.
package plbb_pkg;

    localparam int MaxClusters = 64;
    localparam int CoordBits   = 24;
    localparam int CountBits   = 20;
    localparam int LabelBits   = 8;
    localparam int IdxBits     = $clog2(MaxClusters);
    localparam int MinExtent   = 50;
    localparam int RatioLimit  = 3072;
    localparam int QBits       = CountBits + 8;

    localparam logic [0:0] RegScale = 1'b0;

    typedef logic signed [CoordBits-1:0] t_coord;
    typedef logic [CountBits-1:0]        t_count;

    // One cluster entry as it moves along the chain.
    typedef struct packed {
        t_coord lx;
        t_coord ly;
        t_coord lz;
        t_coord hx;
        t_coord hy;
        t_coord hz;
        t_count cnt;
    } t_entry;

    // A point offered to the chain.
    typedef struct packed {
        logic          valid;
        logic [IdxBits-1:0] idx;
        t_coord        x;
        t_coord        y;
        t_coord        z;
    } t_point;

    typedef enum logic [3:0] {
        ST_ACCUM = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_OUT   = 4'b1000
    } t_state;

    function automatic t_entry entry_clear();
        t_entry e;
        e.lx  = {1'b0, {(CoordBits-1){1'b1}}};
        e.ly  = {1'b0, {(CoordBits-1){1'b1}}};
        e.lz  = {1'b0, {(CoordBits-1){1'b1}}};
        e.hx  = {1'b1, {(CoordBits-1){1'b0}}};
        e.hy  = {1'b1, {(CoordBits-1){1'b0}}};
        e.hz  = {1'b1, {(CoordBits-1){1'b0}}};
        e.cnt = '0;
        return e;
    endfunction

    function automatic logic [16:0] exp_whole(input logic [3:0] i);
        logic [16:0] v;
        unique case (i)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd24109;
            4'd2:    v = 17'd8869;
            4'd3:    v = 17'd3263;
            4'd4:    v = 17'd1200;
            4'd5:    v = 17'd442;
            4'd6:    v = 17'd162;
            4'd7:    v = 17'd60;
            4'd8:    v = 17'd22;
            4'd9:    v = 17'd8;
            4'd10:   v = 17'd3;
            4'd11:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic logic [16:0] exp_sixteenth(input logic [3:0] i);
        logic [16:0] v;
        unique case (i)
            4'd0:  v = 17'd65536;
            4'd1:  v = 17'd61565;
            4'd2:  v = 17'd57835;
            4'd3:  v = 17'd54331;
            4'd4:  v = 17'd51039;
            4'd5:  v = 17'd47947;
            4'd6:  v = 17'd45042;
            4'd7:  v = 17'd42313;
            4'd8:  v = 17'd39750;
            4'd9:  v = 17'd37341;
            4'd10: v = 17'd35079;
            4'd11: v = 17'd32954;
            4'd12: v = 17'd30957;
            4'd13: v = 17'd29081;
            4'd14: v = 17'd27319;
            default: v = 17'd25664;
        endcase
        return v;
    endfunction

    function automatic logic [16:0] exp_fine(input logic [3:0] i);
        logic [16:0] v;
        unique case (i)
            4'd0:  v = 17'd65536;
            4'd1:  v = 17'd65280;
            4'd2:  v = 17'd65026;
            4'd3:  v = 17'd64772;
            4'd4:  v = 17'd64520;
            4'd5:  v = 17'd64268;
            4'd6:  v = 17'd64018;
            4'd7:  v = 17'd63768;
            4'd8:  v = 17'd63520;
            4'd9:  v = 17'd63272;
            4'd10: v = 17'd63025;
            4'd11: v = 17'd62780;
            4'd12: v = 17'd62535;
            4'd13: v = 17'd62291;
            4'd14: v = 17'd62048;
            default: v = 17'd61806;
        endcase
        return v;
    endfunction

endpackage

### sv/plbb_cell.sv
// One chain cell: holds one cluster entry and folds in a point or shifts toward the head.
module plbb_cell
    import plbb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [IdxBits-1:0]   i_my_idx,
    input  t_point               i_point,
    input  logic                 i_shift,
    input  t_entry               i_next,
    output t_entry               o_entry
);

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_shift) begin
            n_entry = i_next;
        end else if (i_point.valid && i_point.idx == i_my_idx) begin
            if (i_point.x < r_entry.lx) n_entry.lx = i_point.x;
            if (i_point.y < r_entry.ly) n_entry.ly = i_point.y;
            if (i_point.z < r_entry.lz) n_entry.lz = i_point.z;
            if (i_point.x > r_entry.hx) n_entry.hx = i_point.x;
            if (i_point.y > r_entry.hy) n_entry.hy = i_point.y;
            if (i_point.z > r_entry.hz) n_entry.hz = i_point.z;
            if (r_entry.cnt != {CountBits{1'b1}}) n_entry.cnt = r_entry.cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= entry_clear();
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

### sv/plbb_conf.sv
// Confidence unit: serial restoring divide of count*256 by scale, then table product.
module plbb_conf
    import plbb_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  t_count       i_count,
    input  logic [15:0]  i_scale,
    output logic         o_done,
    output logic [15:0]  o_conf
);

    localparam int StepBits = $clog2(QBits + 4);

    typedef enum logic [3:0] {
        PH_DIV   = 4'b0001,
        PH_CHECK = 4'b0010,
        PH_MID   = 4'b0100,
        PH_FINE  = 4'b1000
    } t_phase;

    logic [QBits-1:0]    r_quo;
    logic [16:0]         r_rem;
    logic [StepBits-1:0] r_step;
    t_phase              r_ph;
    logic                r_busy;
    logic [16:0]         r_e;
    logic [15:0]         r_conf;
    logic                r_done;
    logic [15:0]         w_div;
    logic [17:0]         w_trial;
    logic [33:0]         w_prod;
    logic [16:0]         w_tab;

    assign w_div   = (i_scale == 16'd0) ? 16'd1 : i_scale;
    assign w_trial = {r_rem, r_quo[QBits-1]} - {2'b00, w_div};
    assign w_tab   = (r_ph == PH_MID) ? exp_sixteenth(r_quo[7:4]) : exp_fine(r_quo[3:0]);
    assign w_prod  = r_e * w_tab + 34'd32768;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ph   <= PH_DIV;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_ph   <= PH_DIV;
                r_step <= '0;
                r_quo  <= {i_count, 8'd0};
                r_rem  <= '0;
            end else if (r_busy && r_ph == PH_DIV) begin
                // one quotient bit per cycle
                if (!w_trial[17]) begin
                    r_rem <= w_trial[16:0];
                    r_quo <= {r_quo[QBits-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[15:0], r_quo[QBits-1]};
                    r_quo <= {r_quo[QBits-2:0], 1'b0};
                end
                r_step <= r_step + 1'b1;
                if (r_step == StepBits'(QBits - 1)) r_ph <= PH_CHECK;
            end else if (r_busy && r_ph == PH_CHECK) begin
                if (r_quo >= QBits'(RatioLimit)) begin
                    r_conf <= 16'hFFFF;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_ph   <= PH_DIV;
                end else begin
                    r_e  <= exp_whole(r_quo[11:8]);
                    r_ph <= PH_MID;
                end
            end else if (r_busy && r_ph == PH_MID) begin
                r_e  <= w_prod[32:16];
                r_ph <= PH_FINE;
            end else if (r_busy && r_ph == PH_FINE) begin
                r_conf <= (w_prod[32:16] == 17'd0) ? 16'hFFFF
                        : 16'(17'h10000 - w_prod[32:16]);
                r_busy <= 1'b0;
                r_done <= 1'b1;
                r_ph   <= PH_DIV;
            end
        end
    end

    assign o_done = r_done;
    assign o_conf = r_conf;

endmodule

### sv/per_label_bounding_box_top.sv
// Top level of the per-label bounding box block: chain of cluster cells, emitter, APB register.
//
// Each cluster label owns one cell of a 64-cell chain; every cell compares an
// incoming point against its label and updates its min, max and count in the
// same cycle, so points are taken one per cycle while the block accumulates. On
// a last point the chain shifts one cell per cycle toward the head while it
// scans, which drains every label in order and refills the tail with cleared
// entries. Each non-empty box goes through a serial divider for its confidence
// (28 quotient steps, then the table steps unless the confidence saturates),
// and the shift pauses until that box is taken, so any output stall holds the
// frame end. An empty frame gives its one result after the scan. Nothing is
// accepted until the last result of the frame is taken.
module per_label_bounding_box_top
    import plbb_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [LabelBits-1:0] i_cluster_label,
    input  logic signed [CoordBits-1:0] i_coord_x,
    input  logic signed [CoordBits-1:0] i_coord_y,
    input  logic signed [CoordBits-1:0] i_coord_z,
    input  logic                        i_last_point,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [6:0]                  o_box_label,
    output logic signed [CoordBits-1:0] o_center_x,
    output logic signed [CoordBits-1:0] o_center_y,
    output logic signed [CoordBits-1:0] o_center_z,
    output logic [CoordBits-1:0]        o_extent_x,
    output logic [CoordBits-1:0]        o_extent_y,
    output logic [CoordBits-1:0]        o_extent_z,
    output logic [CountBits-1:0]        o_member_count,
    output logic [15:0]                 o_confidence,
    output logic                        o_frame_empty,
    output logic                        o_last_box,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    t_state r_state;
    logic [15:0] r_scale;
    logic [IdxBits:0] r_shift_cnt;
    logic r_any;
    t_point w_point;
    logic w_shift;
    logic w_acc;
    t_entry w_ent [MaxClusters];
    t_entry r_head;
    logic [IdxBits:0] r_label;
    logic w_conf_done;
    logic [15:0] w_conf;
    logic signed [CoordBits:0] w_sx, w_sy, w_sz;
    logic [CoordBits:0] w_dx, w_dy, w_dz;
    logic w_final;
    logic r_last_rest;
    logic w_rest_empty;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == RegScale) ? {16'd0, r_scale} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= 16'd25;
        end else if (psel && penable && pwrite && paddr[2] == RegScale) begin
            r_scale <= pwdata[15:0];
        end
    end

    assign o_stall = (r_state != ST_ACCUM);
    assign w_acc   = i_valid && !o_stall;
    assign w_shift = (r_state == ST_SCAN);

    always_comb begin
        w_point.valid = w_acc && i_cluster_label >= 8'sd1
                        && i_cluster_label <= 8'(MaxClusters);
        w_point.idx   = IdxBits'(i_cluster_label - 8'sd1);
        w_point.x     = i_coord_x;
        w_point.y     = i_coord_y;
        w_point.z     = i_coord_z;
    end

    genvar g;
    generate
        for (g = 0; g < MaxClusters; g++) begin : g_cell
            t_entry w_nxt;
            if (g == MaxClusters - 1) begin : g_tail
                assign w_nxt = entry_clear();
            end else begin : g_mid
                assign w_nxt = w_ent[g+1];
            end
            plbb_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_my_idx(IdxBits'(g)),
                .i_point (w_point),
                .i_shift (w_shift),
                .i_next  (w_nxt),
                .o_entry (w_ent[g])
            );
        end
    endgenerate

    plbb_conf u_conf (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_shift && w_ent[0].cnt != '0),
        .i_count(w_ent[0].cnt),
        .i_scale(r_scale),
        .o_done (w_conf_done),
        .o_conf (w_conf)
    );

    assign w_sx = (CoordBits+1)'(r_head.lx) + (CoordBits+1)'(r_head.hx);
    assign w_sy = (CoordBits+1)'(r_head.ly) + (CoordBits+1)'(r_head.hy);
    assign w_sz = (CoordBits+1)'(r_head.lz) + (CoordBits+1)'(r_head.hz);
    assign w_dx = (CoordBits+1)'(r_head.hx) - (CoordBits+1)'(r_head.lx);
    assign w_dy = (CoordBits+1)'(r_head.hy) - (CoordBits+1)'(r_head.ly);
    assign w_dz = (CoordBits+1)'(r_head.hz) - (CoordBits+1)'(r_head.lz);
    assign w_final = (r_shift_cnt == (IdxBits+1)'(MaxClusters));

    // remaining cells (after the head was taken) all empty
    always_comb begin
        w_rest_empty = 1'b1;
        for (int k = 0; k < MaxClusters; k++) begin
            if (w_ent[k].cnt != '0) w_rest_empty = 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        r_last_rest <= w_rest_empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACCUM;
            o_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_ACCUM: begin
                    if (w_acc && i_last_point) begin
                        r_state     <= ST_SCAN;
                        r_shift_cnt <= '0;
                        r_any       <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    r_shift_cnt <= r_shift_cnt + 1'b1;
                    if (w_ent[0].cnt != '0) begin
                        r_head  <= w_ent[0];
                        r_label <= r_shift_cnt + 1'b1;
                        r_any   <= 1'b1;
                        r_state <= ST_DIV;
                    end else if (r_shift_cnt == (IdxBits+1)'(MaxClusters - 1)) begin
                        if (!r_any) begin
                            o_valid        <= 1'b1;
                            o_box_label    <= '0;
                            o_center_x     <= '0;
                            o_center_y     <= '0;
                            o_center_z     <= '0;
                            o_extent_x     <= '0;
                            o_extent_y     <= '0;
                            o_extent_z     <= '0;
                            o_member_count <= '0;
                            o_confidence   <= '0;
                            o_frame_empty  <= 1'b1;
                            o_last_box     <= 1'b1;
                            r_state        <= ST_OUT;
                        end else begin
                            r_state <= ST_ACCUM;
                        end
                    end
                end
                ST_DIV: begin
                    if (w_conf_done) begin
                        o_valid        <= 1'b1;
                        o_box_label    <= 7'(r_label);
                        o_center_x     <= w_sx[CoordBits:1];
                        o_center_y     <= w_sy[CoordBits:1];
                        o_center_z     <= w_sz[CoordBits:1];
                        o_extent_x     <= (w_dx < (CoordBits+1)'(MinExtent))
                                          ? CoordBits'(MinExtent) : w_dx[CoordBits-1:0];
                        o_extent_y     <= (w_dy < (CoordBits+1)'(MinExtent))
                                          ? CoordBits'(MinExtent) : w_dy[CoordBits-1:0];
                        o_extent_z     <= (w_dz < (CoordBits+1)'(MinExtent))
                                          ? CoordBits'(MinExtent) : w_dz[CoordBits-1:0];
                        o_member_count <= r_head.cnt;
                        o_confidence   <= w_conf;
                        o_frame_empty  <= 1'b0;
                        // last box is known once the remaining chain is empty
                        o_last_box     <= r_last_rest;
                        r_state        <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!i_stall) begin
                        o_valid <= 1'b0;
                        if (o_frame_empty || w_final) begin
                            r_state <= ST_ACCUM;
                        end else begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                default: r_state <= ST_ACCUM;
            endcase
        end
    end

    property p_no_accept_busy;
        @(posedge i_clk) disable iff (!i_rst_n) (r_state != ST_ACCUM) |-> o_stall;
    endproperty
    a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

    a_out_only_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == ST_OUT)) else $error("valid outside output state");

    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_last_point) |=> (r_state == ST_SCAN))
        else $error("frame end missed");

endmodule

### bench/tb_top.sv
// Testbench for per_label_bounding_box_top: directed and random point frames, checked per box.
`timescale 1ns / 1ps

module tb_top;
    import plbb_pkg::*;

    localparam longint CycleLimit = 10_000_000;
    localparam int DrainCycles = 64 + 64 * 40;

    typedef struct {
        logic [6:0]  label;
        t_coord      cx, cy, cz;
        logic [23:0] ex, ey, ez;
        t_count      cnt;
        logic [15:0] conf;
        logic        empty;
        logic        last;
    } t_box;

    logic i_clk, i_rst_n;
    logic i_valid, o_stall, o_valid, i_stall;
    logic signed [7:0] i_cluster_label;
    t_coord i_coord_x, i_coord_y, i_coord_z;
    logic i_last_point;
    logic [6:0] o_box_label;
    t_coord o_center_x, o_center_y, o_center_z;
    logic [CoordBits-1:0] o_extent_x, o_extent_y, o_extent_z;
    t_count o_member_count;
    logic [15:0] o_confidence;
    logic o_frame_empty, o_last_box;
    logic psel, penable, pwrite, pready;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;

    per_label_bounding_box_top dut (.*);

    // predictor state
    t_coord lo_x[MaxClusters], lo_y[MaxClusters], lo_z[MaxClusters];
    t_coord hi_x[MaxClusters], hi_y[MaxClusters], hi_z[MaxClusters];
    t_count pts[MaxClusters];
    logic [15:0] conf_scale;
    t_box box_q[$];

    bit send_idle, recv_idle, hold_req;
    int errors, n_points, n_boxes, n_frames;
    longint cycles;

    int unsigned exp_whole_t[12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1};
    int unsigned exp_six_t[16] = '{65536, 61565, 57835, 54331, 51039, 47947, 45042, 42313,
                                   39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664};
    int unsigned exp_fine_t[16] = '{65536, 65280, 65026, 64772, 64520, 64268, 64018, 63768,
                                    63520, 63272, 63025, 62780, 62535, 62291, 62048, 61806};

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("FAIL per_label_bounding_box_top");
            $finish;
        end
    end

    function automatic void clear_boxes();
        for (int k = 0; k < MaxClusters; k++) begin
            lo_x[k] = {1'b0, {(CoordBits-1){1'b1}}};
            lo_y[k] = lo_x[k];
            lo_z[k] = lo_x[k];
            hi_x[k] = {1'b1, {(CoordBits-1){1'b0}}};
            hi_y[k] = hi_x[k];
            hi_z[k] = hi_x[k];
            pts[k] = '0;
        end
    endfunction

    function automatic logic [15:0] confidence_for(t_count c);
        longint unsigned q, e, sc;
        sc = (conf_scale == 0) ? 1 : conf_scale;
        q = ({36'd0, c} << 8) / sc;
        if (q >= RatioLimit) return 16'hFFFF;
        e = exp_whole_t[q >> 8];
        e = (e * exp_six_t[(q >> 4) & 15] + 32768) >> 16;
        e = (e * exp_fine_t[q & 15] + 32768) >> 16;
        return (65536 - e > 65535) ? 16'hFFFF : 16'(65536 - e);
    endfunction

    function automatic t_coord mid_of(t_coord lo, t_coord hi);
        logic signed [CoordBits:0] s;
        s = $signed({lo[CoordBits-1], lo}) + $signed({hi[CoordBits-1], hi});
        return s[CoordBits:1];
    endfunction

    function automatic logic [23:0] size_of(t_coord lo, t_coord hi);
        logic signed [CoordBits:0] d;
        d = $signed({hi[CoordBits-1], hi}) - $signed({lo[CoordBits-1], lo});
        return (d < MinExtent) ? 24'(MinExtent) : d[CoordBits-1:0];
    endfunction

    // update the boxes with one accepted point, queue the boxes a frame end releases
    function automatic void absorb_point(logic signed [7:0] lab, t_coord x, t_coord y,
                                         t_coord z, logic last);
        int k;
        t_box b;
        int n;
        n = 0;
        if (lab >= 1 && lab <= MaxClusters) begin
            k = lab - 1;
            if (x < lo_x[k]) lo_x[k] = x;
            if (y < lo_y[k]) lo_y[k] = y;
            if (z < lo_z[k]) lo_z[k] = z;
            if (x > hi_x[k]) hi_x[k] = x;
            if (y > hi_y[k]) hi_y[k] = y;
            if (z > hi_z[k]) hi_z[k] = z;
            if (pts[k] != '1) pts[k] = pts[k] + 1;
        end
        if (!last) return;
        n_frames++;
        for (k = 0; k < MaxClusters; k++) begin
            if (pts[k] == 0) continue;
            b.label = 7'(k + 1);
            b.cx = mid_of(lo_x[k], hi_x[k]);
            b.cy = mid_of(lo_y[k], hi_y[k]);
            b.cz = mid_of(lo_z[k], hi_z[k]);
            b.ex = size_of(lo_x[k], hi_x[k]);
            b.ey = size_of(lo_y[k], hi_y[k]);
            b.ez = size_of(lo_z[k], hi_z[k]);
            b.cnt = pts[k];
            b.conf = confidence_for(pts[k]);
            b.empty = 0;
            b.last = 0;
            box_q = {box_q, b};
            n++;
        end
        if (n == 0) begin
            b = '{default: '0};
            b.empty = 1;
            box_q = {box_q, b};
        end
        box_q[box_q.size()-1].last = 1;
        clear_boxes();
    endfunction

    task automatic send_point(logic signed [7:0] lab, t_coord x, t_coord y, t_coord z,
                              logic last);
        @(negedge i_clk);
        while (send_idle && $urandom_range(99) < 36) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid <= 1;
        i_cluster_label <= lab;
        i_coord_x <= x;
        i_coord_y <= y;
        i_coord_z <= z;
        i_last_point <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        absorb_point(lab, x, y, z, last);
        n_points++;
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        i_valid <= 0;
    endtask

    // block is idle once every box is out and the chain has had time to drain
    task automatic wait_idle();
        end_burst();
        while (box_q.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        @(negedge i_clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0;
        penable <= 0;
        if ((addr >> 2) == RegScale) conf_scale = data[15:0];
    endtask

    // receiver side
    always @(negedge i_clk)
        i_stall <= hold_req || (recv_idle && $urandom_range(99) < 36);

    // long receiver hold-off, counted here
    initial forever begin
        wait (hold_req);
        repeat (400) @(posedge i_clk);
        hold_req = 0;
    end

    always @(posedge i_clk) begin
        t_box b;
        if (i_rst_n && o_valid && !i_stall) begin
            if (box_q.size() == 0) begin
                $error("box with no expectation, label %0d", o_box_label);
                errors++;
            end else begin
                b = box_q.pop_front();
                n_boxes++;
                if (o_box_label !== b.label) begin
                    $error("box_label exp %0d got %0d", b.label, o_box_label); errors++;
                end
                if (o_center_x !== b.cx) begin
                    $error("center_x exp %0d got %0d", b.cx, o_center_x); errors++;
                end
                if (o_center_y !== b.cy) begin
                    $error("center_y exp %0d got %0d", b.cy, o_center_y); errors++;
                end
                if (o_center_z !== b.cz) begin
                    $error("center_z exp %0d got %0d", b.cz, o_center_z); errors++;
                end
                if (o_extent_x !== b.ex) begin
                    $error("extent_x exp %0d got %0d", b.ex, o_extent_x); errors++;
                end
                if (o_extent_y !== b.ey) begin
                    $error("extent_y exp %0d got %0d", b.ey, o_extent_y); errors++;
                end
                if (o_extent_z !== b.ez) begin
                    $error("extent_z exp %0d got %0d", b.ez, o_extent_z); errors++;
                end
                if (o_member_count !== b.cnt) begin
                    $error("member_count exp %0d got %0d", b.cnt, o_member_count); errors++;
                end
                if (o_confidence !== b.conf) begin
                    $error("confidence exp %0d got %0d", b.conf, o_confidence); errors++;
                end
                if (o_frame_empty !== b.empty) begin
                    $error("frame_empty exp %0d got %0d", b.empty, o_frame_empty); errors++;
                end
                if (o_last_box !== b.last) begin
                    $error("last_box exp %0d got %0d", b.last, o_last_box); errors++;
                end
            end
        end
    end

    function automatic t_coord near(t_coord c);
        if ($urandom_range(9) < 2) return t_coord'($urandom);
        return c + t_coord'($urandom_range(400)) - 200;
    endfunction

    task automatic test_extremes();
        t_coord pos, neg;
        pos = {1'b0, {(CoordBits-1){1'b1}}};
        neg = {1'b1, {(CoordBits-1){1'b0}}};
        // widest box, floor of a negative half
        send_point(8'sd1, neg, neg, pos, 0);
        send_point(8'sd1, pos, pos, neg, 0);
        // lone point: extent clamps to the minimum
        send_point(8'sd64, 24'sd5, -24'sd7, 24'sd0, 0);
        send_point(8'sd2, -24'sd3, 24'sd0, 24'sd10, 0);
        send_point(8'sd2, 24'sd0, 24'sd49, 24'sd61, 0);
        // noise labels never count
        send_point(-8'sd1, pos, pos, pos, 0);
        send_point(8'sd0, neg, neg, neg, 0);
        send_point(8'sd65, 24'sd1, 24'sd1, 24'sd1, 0);
        send_point(-8'sd128, 24'h555555, 24'hAAAAAA, 24'h0F0F0F, 0);
        send_point(8'sd127, 24'hAAAAAA, 24'h555555, 24'hF0F0F0, 0);
        send_point(8'sd3, 24'sd100, 24'sd100, 24'sd100, 1);
        // empty frame: noise point ends it
        send_point(-8'sd1, 24'sd0, 24'sd0, 24'sd0, 1);
        send_point(8'sd0, 24'sd0, 24'sd0, 24'sd0, 1);
        // last point on a counted label alone
        send_point(8'sd64, neg, pos, 24'sd0, 1);
        wait_idle();
    endtask

    task automatic test_config();
        logic [31:0] scales[5] = '{32'd0, 32'd1, 32'd65535, 32'hFFFF_0007, 32'd25};
        foreach (scales[s]) begin
            write_reg(3'd4, 32'd3);   // no register there
            write_reg(3'd0, scales[s]);
            for (int n = 1; n <= 4; n++)
                for (int j = 0; j < n * 3; j++)
                    send_point(8'(n), t_coord'($urandom), t_coord'($urandom),
                               t_coord'($urandom), 0);
            send_point(8'sd5, 24'sd0, 24'sd0, 24'sd0, 1);
            wait_idle();
        end
    endtask

    task automatic random_frames(int budget);
        int sent, len, nlab;
        logic signed [7:0] labs[4];
        t_coord cx[4], cy[4], cz[4];
        int r;
        sent = 0;
        while (sent < budget) begin
            len = $urandom_range(24, 1);
            nlab = $urandom_range(4, 1);
            for (int j = 0; j < 4; j++) begin
                labs[j] = 8'($urandom_range(MaxClusters, 1));
                cx[j] = t_coord'($urandom);
                cy[j] = t_coord'($urandom);
                cz[j] = t_coord'($urandom);
            end
            for (int j = 0; j < len; j++) begin
                r = $urandom_range(nlab - 1);
                if ($urandom_range(9) == 0)
                    send_point(8'($urandom_range(130) - 1 > 127 ? -1 : $urandom_range(130) - 65),
                               t_coord'($urandom), t_coord'($urandom), t_coord'($urandom),
                               j == len - 1);
                else
                    send_point(labs[r], near(cx[r]), near(cy[r]), near(cz[r]), j == len - 1);
            end
            sent += len;
        end
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 4; phase++) begin
            if (phase == 1) write_reg(3'd0, $urandom_range(12, 1));
            if (phase == 2) write_reg(3'd0, $urandom_range(65535, 1));
            if (phase == 3) write_reg(3'd0, $urandom_range(40, 2));
            send_idle = (phase != 2);
            recv_idle = (phase != 2);
            random_frames(60);
            wait_idle();
        end
        send_idle = 1;
        recv_idle = 1;
    endtask

    task automatic test_backpressure();
        hold_req = 1;
        random_frames(40);
        wait_idle();
    endtask

    task automatic test_long_cluster();
        send_idle = 0;
        recv_idle = 0;
        for (int j = 0; j < 30; j++)
            send_point(8'sd7, t_coord'(j * 1000), t_coord'(-j), 24'sd9, 0);
        send_point(8'sd7, 24'sd0, 24'sd0, 24'sd0, 1);
        wait_idle();
        send_idle = 1;
        recv_idle = 1;
    endtask

    initial begin
        i_rst_n = 0;
        i_valid = 0;
        i_stall = 0;
        i_cluster_label = '0;
        i_coord_x = '0;
        i_coord_y = '0;
        i_coord_z = '0;
        i_last_point = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        cycles = 0;
        errors = 0;
        send_idle = 1;
        recv_idle = 1;
        hold_req = 0;
        conf_scale = 16'd25;
        clear_boxes();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        repeat (DrainCycles) @(posedge i_clk);

        test_extremes();
        test_config();
        test_random();
        test_backpressure();
        test_long_cluster();

        $display("Covered %0d points over %0d frames, %0d boxes checked;", n_points, n_frames,
                 n_boxes);
        $display("noise labels, empty frames, scale extremes, hold-off and a long cluster.");
        if (errors == 0 && box_q.size() == 0)
            $display("PASS per_label_bounding_box_top");
        else
            $display("FAIL per_label_bounding_box_top");
        $finish;
    end

endmodule

### per_label_bounding_box_top.f
sv/plbb_pkg.sv
sv/plbb_cell.sv
sv/plbb_conf.sv
sv/per_label_bounding_box_top.sv
bench/tb_top.sv
